// ===== design/ica_pkg.sv =====
// Shared types and constants for the IPv4 connection admission block.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package ica_pkg;

	localparam int ADDR_W   = 32;
	localparam int RIGHTS_W = 3;

	// rule entry: {address, mask, rights}
	localparam int RULE_W = 2 * ADDR_W + RIGHTS_W;
	// good cache entry: {address, rights}
	localparam int GOOD_W = ADDR_W + RIGHTS_W;
	// bad cache entry: address only
	localparam int BAD_W  = ADDR_W;

	localparam int RULE_SLOTS_DEF  = 16;
	localparam int CACHE_SLOTS_DEF = 128;

	localparam logic OP_RULE  = 1'b0;
	localparam logic OP_ADMIT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GOOD,
		ST_BAD,
		ST_RULE,
		ST_DONE
	} state_t;

endpackage

// ===== design/ica_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ica_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/ipv4_connection_admission.sv =====
// Top level of the IPv4 connection admission block: sequencer, scan datapath, result register.
// Depends on ica_pkg and three instances of ica_ram.
`timescale 1ns / 1ps

// Admits IPv4 connections against a first-match masked rule table, with two
// learning caches in front of it. A transaction with operation OP_RULE appends
// {address, mask, rights} to the rule table (rule_dropped when it is full). A
// transaction with operation OP_ADMIT scans the good cache, then the bad cache,
// then the rule table, one entry per cycle through each memory's single read
// port, and stops at the first hit; a hit ends its scan early. A rule search
// writes the address into the good cache (match) or the bad cache (miss); a
// full cache overwrites its last slot. One item is processed at a time;
// in_ready is high whenever the sequencer is idle, and a finished result waits
// in the output register so the next item can start while it is unclaimed.
// Cache and rule memories are not cleared; fill counts bound every scan, so
// no reset sweep is needed.
module ipv4_connection_admission
	import ica_pkg::*;
#(
	parameter int RULE_SLOTS  = RULE_SLOTS_DEF,
	parameter int CACHE_SLOTS = CACHE_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	input  logic [ADDR_W-1:0]   address,
	input  logic [ADDR_W-1:0]   mask,
	input  logic [RIGHTS_W-1:0] rights,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [RIGHTS_W-1:0] granted,
	output logic                refused,
	output logic                repeat_offender,
	output logic                learned,
	output logic                rule_dropped
);

	localparam int RIDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int CIDX_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
	localparam int RCNT_W = $clog2(RULE_SLOTS + 1);
	localparam int CCNT_W = $clog2(CACHE_SLOTS + 1);
	localparam int MAX_SLOTS = (RULE_SLOTS > CACHE_SLOTS) ? RULE_SLOTS : CACHE_SLOTS;
	localparam int SCAN_W = $clog2(MAX_SLOTS + 1);

	state_t state_q, state_d;

	logic [RCNT_W-1:0] rule_count_q;
	logic [CCNT_W-1:0] good_count_q;
	logic [CCNT_W-1:0] bad_count_q;

	logic [SCAN_W-1:0] scan_idx_q;
	logic              rd_pending_s1;
	logic [ADDR_W-1:0] addr_q;

	// result of the current item, held until the output register is free
	logic [RIGHTS_W-1:0] res_granted_q;
	logic                res_refused_q;
	logic                res_repeat_q;
	logic                res_learned_q;
	logic                res_dropped_q;

	logic [RIGHTS_W-1:0] granted_q;
	logic                refused_q;
	logic                repeat_q;
	logic                learned_q;
	logic                dropped_q;
	logic                out_valid_q;

	logic [RULE_W-1:0] rule_rd_data;
	logic [GOOD_W-1:0] good_rd_data;
	logic [BAD_W-1:0]  bad_rd_data;

	logic [ADDR_W-1:0]   rule_rd_addr_f;
	logic [ADDR_W-1:0]   rule_rd_mask_f;
	logic [RIGHTS_W-1:0] rule_rd_rights_f;

	logic              accept;
	logic              rule_full;
	logic              good_full;
	logic              bad_full;
	logic [SCAN_W-1:0] limit;
	logic              hit;
	logic              more;
	logic              issue;
	logic              out_free;

	logic              rule_wr_en;
	logic              good_wr_en;
	logic              bad_wr_en;
	logic [CIDX_W-1:0] good_slot;
	logic [CIDX_W-1:0] bad_slot;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign rule_full = (rule_count_q >= RCNT_W'(RULE_SLOTS));
	assign good_full = (good_count_q >= CCNT_W'(CACHE_SLOTS));
	assign bad_full  = (bad_count_q  >= CCNT_W'(CACHE_SLOTS));

	// full caches overwrite their last slot
	assign good_slot = good_full ? CIDX_W'(CACHE_SLOTS - 1) : good_count_q[CIDX_W-1:0];
	assign bad_slot  = bad_full  ? CIDX_W'(CACHE_SLOTS - 1) : bad_count_q[CIDX_W-1:0];

	assign rule_rd_addr_f   = rule_rd_data[RULE_W-1 -: ADDR_W];
	assign rule_rd_mask_f   = rule_rd_data[RIGHTS_W +: ADDR_W];
	assign rule_rd_rights_f = rule_rd_data[RIGHTS_W-1:0];

	// Scan control: one read issued per cycle, compare the entry read last cycle.
	always_comb begin
		limit = '0;
		hit   = 1'b0;
		unique case (state_q)
			ST_GOOD: begin
				limit = SCAN_W'(good_count_q);
				hit   = rd_pending_s1 && (good_rd_data[GOOD_W-1 -: ADDR_W] == addr_q);
			end
			ST_BAD: begin
				limit = SCAN_W'(bad_count_q);
				hit   = rd_pending_s1 && (bad_rd_data == addr_q);
			end
			ST_RULE: begin
				limit = SCAN_W'(rule_count_q);
				hit   = rd_pending_s1 && ((addr_q & rule_rd_mask_f) == rule_rd_addr_f);
			end
			ST_IDLE, ST_DONE: begin
				limit = '0;
				hit   = 1'b0;
			end
			default: begin
				limit = '0;
				hit   = 1'b0;
			end
		endcase
	end

	assign more  = (scan_idx_q < limit);
	assign issue = (state_q == ST_GOOD || state_q == ST_BAD || state_q == ST_RULE)
		&& !hit && more;

	// Next state and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (operation == OP_RULE) ? ST_DONE : ST_GOOD;
				end
			end
			ST_GOOD: begin
				if (hit) begin
					state_d = ST_DONE;
				end else if (!more) begin
					state_d = ST_BAD;
				end
			end
			ST_BAD: begin
				if (hit) begin
					state_d = ST_DONE;
				end else if (!more) begin
					state_d = ST_RULE;
				end
			end
			ST_RULE: begin
				if (hit || !more) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Memory writes: append a rule at accept, learn an address at the end of a rule search.
	assign rule_wr_en = accept && (operation == OP_RULE) && !rule_full;
	assign good_wr_en = (state_q == ST_RULE) && hit;
	assign bad_wr_en  = (state_q == ST_RULE) && !hit && !more;

	ica_ram #(
		.WIDTH (RULE_W),
		.DEPTH (RULE_SLOTS)
	) u_rule_ram (
		.clk     (clk),
		.wr_en   (rule_wr_en),
		.wr_addr (rule_count_q[RIDX_W-1:0]),
		.wr_data ({address, mask, rights}),
		.rd_addr (scan_idx_q[RIDX_W-1:0]),
		.rd_data (rule_rd_data)
	);

	ica_ram #(
		.WIDTH (GOOD_W),
		.DEPTH (CACHE_SLOTS)
	) u_good_ram (
		.clk     (clk),
		.wr_en   (good_wr_en),
		.wr_addr (good_slot),
		.wr_data ({addr_q, rule_rd_rights_f}),
		.rd_addr (scan_idx_q[CIDX_W-1:0]),
		.rd_data (good_rd_data)
	);

	ica_ram #(
		.WIDTH (BAD_W),
		.DEPTH (CACHE_SLOTS)
	) u_bad_ram (
		.clk     (clk),
		.wr_en   (bad_wr_en),
		.wr_addr (bad_slot),
		.wr_data (addr_q),
		.rd_addr (scan_idx_q[CIDX_W-1:0]),
		.rd_data (bad_rd_data)
	);

	// Scan counter and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q    <= '0;
			rd_pending_s1 <= 1'b0;
			rule_count_q  <= '0;
			good_count_q  <= '0;
			bad_count_q   <= '0;
		end else begin
			// restart the scan whenever the sequencer moves on
			if (state_d != state_q) begin
				scan_idx_q <= '0;
			end else if (issue) begin
				scan_idx_q <= scan_idx_q + SCAN_W'(1);
			end
			rd_pending_s1 <= issue && (state_d == state_q);
			if (rule_wr_en) begin
				rule_count_q <= rule_count_q + RCNT_W'(1);
			end
			if (good_wr_en && !good_full) begin
				good_count_q <= good_count_q + CCNT_W'(1);
			end
			if (bad_wr_en && !bad_full) begin
				bad_count_q <= bad_count_q + CCNT_W'(1);
			end
		end
	end

	// Hold the client address for the scans
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= address;
		end
	end

	// Capture the item's result as its work finishes
	always_ff @(posedge clk) begin
		if (accept && operation == OP_RULE) begin
			res_granted_q <= '0;
			res_refused_q <= 1'b0;
			res_repeat_q  <= 1'b0;
			res_learned_q <= 1'b0;
			res_dropped_q <= rule_full;
		end else if (state_q == ST_GOOD && hit) begin
			res_granted_q <= good_rd_data[RIGHTS_W-1:0];
			res_refused_q <= 1'b0;
			res_repeat_q  <= 1'b0;
			res_learned_q <= 1'b0;
			res_dropped_q <= 1'b0;
		end else if (state_q == ST_BAD && hit) begin
			res_granted_q <= '0;
			res_refused_q <= 1'b1;
			res_repeat_q  <= 1'b1;
			res_learned_q <= 1'b0;
			res_dropped_q <= 1'b0;
		end else if (state_q == ST_RULE && (hit || !more)) begin
			res_granted_q <= hit ? rule_rd_rights_f : '0;
			res_refused_q <= !hit;
			res_repeat_q  <= 1'b0;
			res_learned_q <= 1'b1;
			res_dropped_q <= 1'b0;
		end
	end

	// Output register: load when the previous result has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			granted_q <= res_granted_q;
			refused_q <= res_refused_q;
			repeat_q  <= res_repeat_q;
			learned_q <= res_learned_q;
			dropped_q <= res_dropped_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign granted         = granted_q;
	assign refused         = refused_q;
	assign repeat_offender = repeat_q;
	assign learned         = learned_q;
	assign rule_dropped    = dropped_q;

endmodule

// ===== design/ica_checker.sv =====
// Port-level checker for the IPv4 connection admission block, bound to the top level.
// Depends on ica_pkg.
`timescale 1ns / 1ps

module ica_checker
	import ica_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                operation,
	input logic                out_valid,
	input logic                out_ready,
	input logic [RIGHTS_W-1:0] granted,
	input logic                refused,
	input logic                repeat_offender,
	input logic                learned,
	input logic                rule_dropped
);

	// a stalled result holds its valid, granted, refused and learned outputs
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(granted) && $stable(refused)
			&& $stable(learned))
		else $error("result changed while stalled");

	// a refusal never grants rights and never reports a dropped rule
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && refused |-> granted == '0 && !rule_dropped)
		else $error("refused result grants rights");

	// a repeat offender is refused and never learned again
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && repeat_offender |-> refused && !learned)
		else $error("repeat offender not refused or relearned");

	// a rule append's result is not yet valid in the cycle after it is accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == OP_RULE && !out_valid |=> !out_valid)
		else $error("rule result appeared too early");

endmodule

bind ipv4_connection_admission ica_checker u_ica_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.operation       (operation),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.granted         (granted),
	.refused         (refused),
	.repeat_offender (repeat_offender),
	.learned         (learned),
	.rule_dropped    (rule_dropped)
);
